>>> rtl/ppce_pkg.sv
`timescale 1ns / 1ps
package ppce_pkg;

  localparam int CHAIN_DEPTH   = 1024;
  localparam int SITE_AW       = $clog2(CHAIN_DEPTH);
  localparam int LEN_W         = SITE_AW + 1;
  localparam int CHAIN_MIN_LEN = 3;
  localparam int FRAC          = 24;
  localparam int TABLE_DEPTH   = 1024;
  localparam int TAB_AW        = $clog2(TABLE_DEPTH);
  localparam int SINE_W        = FRAC + 2;

  localparam int WORD_W  = 32;
  localparam int SCALE_W = 31;
  localparam int ANGLE_W = 26;
  localparam int GAIN_W  = 31;
  localparam int STEP_W  = FRAC;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 2;

  // sum of scaled noise over the whole chain
  localparam int SUM_W = WORD_W + SITE_AW;

  localparam int NUM_REGS = 5;
  localparam int PADDR_W  = $clog2(4 * NUM_REGS);
  localparam int REG_W    = PADDR_W - 2;

  localparam logic [REG_W-1:0] REG_SITES      = REG_W'(0);
  localparam logic [REG_W-1:0] REG_ELASTIC    = REG_W'(1);
  localparam logic [REG_W-1:0] REG_DRIVE      = REG_W'(2);
  localparam logic [REG_W-1:0] REG_STEP       = REG_W'(3);
  localparam logic [REG_W-1:0] REG_NOISE_GAIN = REG_W'(4);

  localparam logic [KIND_W-1:0] KIND_LOAD  = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_NOISE = KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_STEP  = KIND_W'(2);
  localparam logic [KIND_W-1:0] KIND_READ  = KIND_W'(3);

  localparam logic [STAT_W-1:0] STATUS_OK    = STAT_W'(0);
  localparam logic [STAT_W-1:0] STATUS_RANGE = STAT_W'(1);
  localparam logic [STAT_W-1:0] STATUS_ANGLE = STAT_W'(2);

  localparam logic [ANGLE_W-1:0] ANGLE_MAX   = ANGLE_W'(2 << FRAC);
  localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(167772);
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(1 << FRAC);

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [SITE_AW-1:0]       site_index;
    logic signed [WORD_W-1:0] phase_value;
    logic [SCALE_W-1:0]       pin_force_scale;
    logic [ANGLE_W-1:0]       pin_angle;
    logic signed [WORD_W-1:0] noise_sample;
  } in_word_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [WORD_W-1:0] phase_out;
    logic signed [WORD_W-1:0] rate_out;
  } out_word_t;

  // sine ROM, one full turn, Q30 Taylor series rounded to FRAC bits
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic signed [SINE_W-1:0] sine_rom_t [TABLE_DEPTH];

  function automatic logic signed [SINE_W-1:0] sine_entry(input int unsigned k);
    logic [63:0] u;
    logic [63:0] f;
    logic [63:0] r;
    logic [63:0] r2;
    logic [63:0] t;
    logic [63:0] s;
    logic [1:0]  q;
    u = (64'(k) << 32) / TABLE_DEPTH;
    q = u[31:30];
    f = (u << 2) & 64'hFFFF_FFFF;
    if (q[0]) f = 64'h1_0000_0000 - f;
    r  = (f * HALF_PI_Q30) >> 32;
    r2 = (r * r) >> 30;
    t  = Q30_ONE - r2 / 110;
    t  = Q30_ONE - ((r2 * t) >> 30) / 72;
    t  = Q30_ONE - ((r2 * t) >> 30) / 42;
    t  = Q30_ONE - ((r2 * t) >> 30) / 20;
    t  = Q30_ONE - ((r2 * t) >> 30) / 6;
    s  = (r * t) >> 30;
    s  = (s + ((64'd1 << (30 - FRAC)) >> 1)) >> (30 - FRAC);
    return q[1] ? -SINE_W'(s) : SINE_W'(s);
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int k = 0; k < TABLE_DEPTH; k++) rom[k] = sine_entry(k);
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

>>> rtl/ppce_ram.sv
`timescale 1ns / 1ps
module ppce_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/pinned_phase_chain_euler_step_unit.sv
`timescale 1ns / 1ps
// Channel   | Handshake            | Word
// ----------+----------------------+-------------------------------------------
// item in   | start & !busy        | item   : ppce_pkg::in_word_t
// result    | done (1-cycle pulse) | result : ppce_pkg::out_word_t
// config    | APB psel/penable     | paddr, pwdata, prdata (pready tied high)
//
// After reset the site stores are zeroed, one entry a cycle, with busy held high.
// Load, noise and read items: the result is registered in ST_ITEM.
// Run step: three passes (noise sum over the pin RAM, rates and phase update
// over the site RAM) at one site a cycle, plus a bit-serial divide for the
// noise mean.
// One word in flight at a time; results cannot be stalled.
module pinned_phase_chain_euler_step_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  ppce_pkg::in_word_t             item,
  output logic                           done,
  output ppce_pkg::out_word_t            result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ppce_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import ppce_pkg::*;

  localparam int DIFF_W   = WORD_W + 1;
  localparam int PROD_N_W = GAIN_W + 1 + WORD_W;
  localparam int PROD_E_W = GAIN_W + 1 + DIFF_W;
  localparam int PROD_P_W = SCALE_W + 1 + SINE_W;
  localparam int PROD_S_W = WORD_W + STEP_W + 1;
  localparam int EL_W     = PROD_E_W - FRAC + 1;
  localparam int MEAN_W   = WORD_W + 1;
  localparam int SAT_W    = 48;
  localparam int DIV_CW   = $clog2(SUM_W);

  // phase and rate share one RAM row; pin data and raw noise the other
  typedef struct packed {
    logic signed [WORD_W-1:0] phase;
    logic signed [WORD_W-1:0] rate;
  } site_rec_t;

  typedef struct packed {
    logic [SCALE_W-1:0]       scale;
    logic [ANGLE_W-1:0]       angle;
    logic signed [WORD_W-1:0] noise;
  } pin_rec_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_ITEM, ST_SUM, ST_DIV, ST_RATE, ST_PHASE
  } state_t;

  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    if (v > SAT_W'(64'sd2147483647)) return WORD_W'(32'h7FFF_FFFF);
    if (v < -SAT_W'(64'sd2147483648)) return WORD_W'(32'h8000_0000);
    return WORD_W'(v);
  endfunction

  // ---------------------------------------------------------------- config
  logic [LEN_W-1:0]         sites_in_use;
  logic [GAIN_W-1:0]        elastic_gain;
  logic signed [WORD_W-1:0] drive_field;
  logic [STEP_W-1:0]        step_length;
  logic [GAIN_W-1:0]        noise_gain;
  logic [REG_W-1:0]         cfg_idx;
  logic                     cfg_we;
  logic [LEN_W-1:0]         n_len;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[PADDR_W-1:2];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      sites_in_use <= LEN_W'(CHAIN_DEPTH);
      elastic_gain <= GAIN_RESET;
      drive_field  <= '0;
      step_length  <= STEP_RESET;
      noise_gain   <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SITES:      sites_in_use <= pwdata[LEN_W-1:0];
        REG_ELASTIC:    elastic_gain <= pwdata[GAIN_W-1:0];
        REG_DRIVE:      drive_field  <= $signed(pwdata);
        REG_STEP:       step_length  <= pwdata[STEP_W-1:0];
        REG_NOISE_GAIN: noise_gain   <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SITES:      prdata = 32'(sites_in_use);
      REG_ELASTIC:    prdata = 32'(elastic_gain);
      REG_DRIVE:      prdata = 32'(unsigned'(drive_field));
      REG_STEP:       prdata = 32'(step_length);
      REG_NOISE_GAIN: prdata = 32'(noise_gain);
      default:        prdata = '0;
    endcase
  end

  // chain length clamped to the legal span
  always_comb begin
    if (sites_in_use < LEN_W'(CHAIN_MIN_LEN))      n_len = LEN_W'(CHAIN_MIN_LEN);
    else if (sites_in_use > LEN_W'(CHAIN_DEPTH))   n_len = LEN_W'(CHAIN_DEPTH);
    else                                           n_len = sites_in_use;
  end

  // ---------------------------------------------------------------- RAMs
  logic               s_we, p_we;
  logic [SITE_AW-1:0] s_waddr, s_raddr, p_waddr, p_raddr;
  site_rec_t          s_wdata, s_rdata;
  pin_rec_t           p_wdata, p_rdata;

  ppce_ram #(.WIDTH($bits(site_rec_t)), .DEPTH(CHAIN_DEPTH)) u_site_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  ppce_ram #(.WIDTH($bits(pin_rec_t)), .DEPTH(CHAIN_DEPTH)) u_pin_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  // ---------------------------------------------------------------- control
  state_t                   state;
  logic [LEN_W-1:0]         clr_cnt;
  logic [LEN_W-1:0]         rd_cnt;
  logic                     rdv, dv, v1, v2, v3;
  in_word_t                 cur;
  logic signed [SUM_W-1:0]  acc;
  logic                     div_neg;
  logic [SUM_W-1:0]         div_q;
  logic [LEN_W-1:0]         div_rem;
  logic [DIV_CW-1:0]        div_cnt;
  logic signed [MEAN_W-1:0] mean;
  logic signed [WORD_W-1:0] r2_sn;

  logic                     issue, site_out, pipe_idle;
  logic [LEN_W-1:0]         issue_site;
  logic [LEN_W:0]           rem_sh;
  logic                     q_bit;
  logic [LEN_W-1:0]         rem_next;
  logic                     in_range;
  out_word_t                item_res;

  assign busy = (state != ST_IDLE);

  // RATE pass reads N+2 phases: last site first, then 0..N-1, then site 0 again
  always_comb begin
    case (state)
      ST_SUM, ST_PHASE: issue = (rd_cnt < n_len);
      ST_RATE:          issue = (rd_cnt < n_len + LEN_W'(2));
      default:          issue = 1'b0;
    endcase
    site_out   = (state != ST_RATE) || (rd_cnt >= LEN_W'(2));
    issue_site = (state == ST_RATE) ? rd_cnt - LEN_W'(2) : rd_cnt;
  end

  assign pipe_idle = !rdv && !dv && !v1 && !v2 && !v3;

  // restoring divide, one quotient bit a cycle
  always_comb begin
    rem_sh   = {div_rem, div_q[SUM_W-1]};
    q_bit    = (rem_sh >= {1'b0, n_len});
    rem_next = q_bit ? LEN_W'(rem_sh - {1'b0, n_len}) : LEN_W'(rem_sh);
  end

  always_comb begin
    in_range = ({1'b0, cur.site_index} < n_len);
    item_res = '0;
    if (!in_range) begin
      item_res.status = STATUS_RANGE;
    end else if (cur.kind == KIND_LOAD && cur.pin_angle > ANGLE_MAX) begin
      item_res.status = STATUS_ANGLE;
    end else if (cur.kind == KIND_READ) begin
      item_res.phase_out = s_rdata.phase;
      item_res.rate_out  = s_rdata.rate;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      rd_cnt  <= '0;
      rdv     <= 1'b0;
      dv      <= 1'b0;
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      div_cnt <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      rdv  <= issue;
      dv   <= issue && site_out;
      v1   <= dv;
      v2   <= v1;
      v3   <= v2;
      if (issue) rd_cnt <= rd_cnt + LEN_W'(1);
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + LEN_W'(1);
          if (clr_cnt == LEN_W'(CHAIN_DEPTH - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (start) begin
            cur    <= item;
            rd_cnt <= '0;
            acc    <= '0;
            state  <= (item.kind == KIND_STEP) ? ST_SUM : ST_ITEM;
          end
        end
        ST_ITEM: begin
          done   <= 1'b1;
          result <= item_res;
          state  <= ST_IDLE;
        end
        ST_SUM: begin
          if (v2) acc <= acc + SUM_W'(r2_sn);
          if (!issue && pipe_idle) begin
            div_neg <= acc[SUM_W-1];
            div_q   <= acc[SUM_W-1] ? SUM_W'(-acc) : SUM_W'(acc);
            div_rem <= '0;
            div_cnt <= '0;
            rd_cnt  <= '0;
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          div_rem <= rem_next;
          div_q   <= {div_q[SUM_W-2:0], q_bit};
          div_cnt <= div_cnt + DIV_CW'(1);
          if (div_cnt == DIV_CW'(SUM_W - 1)) state <= ST_RATE;
        end
        ST_RATE: begin
          // quotient settled; mean truncates toward zero
          if (rd_cnt == '0) begin
            mean <= div_neg ? -$signed({1'b0, div_q[WORD_W-1:0]})
                            :  $signed({1'b0, div_q[WORD_W-1:0]});
          end
          if (!issue && pipe_idle) begin
            rd_cnt <= '0;
            state  <= ST_PHASE;
          end
        end
        ST_PHASE: begin
          if (!issue && pipe_idle) begin
            done   <= 1'b1;
            result <= '0;
            state  <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath
  logic signed [WORD_W-1:0]   w_c, w_r;
  logic [SITE_AW-1:0]         ds_site, r1_site, r2_site, r3_site;
  logic signed [WORD_W-1:0]   r1_phase, r2_phase, r3_phase, r1_rate;
  logic signed [DIFF_W-1:0]   r1_diff_r, r1_diff_l;
  logic [TAB_AW-1:0]          r1_idx;
  logic [SCALE_W-1:0]         r1_scale, r2_scale;
  logic signed [PROD_N_W-1:0] r1_prod_n;
  logic signed [PROD_S_W-1:0] r1_prod_s;
  logic signed [PROD_E_W-1:0] r2_prod_r, r2_prod_l;
  logic signed [SINE_W-1:0]   r2_sine;
  logic signed [EL_W-1:0]     r3_el;
  logic signed [PROD_P_W-1:0] r3_prod_p;
  logic signed [WORD_W-1:0]   r3_force;
  logic signed [DIFF_W-1:0]   d_pin;
  logic signed [WORD_W-1:0]   rate_new;
  logic signed [WORD_W-1:0]   phase_new;

  // centre phase minus pin angle; wrap mod 2.0 is the low bits
  assign d_pin = DIFF_W'(w_r) - $signed({1'b0, p_rdata.angle});

  always_ff @(posedge clk) begin
    if (issue) ds_site <= issue_site[SITE_AW-1:0];
    if (rdv) begin
      w_c <= w_r;
      w_r <= s_rdata.phase;
    end
    if (dv) begin
      r1_site   <= ds_site;
      r1_phase  <= (state == ST_RATE) ? w_r : s_rdata.phase;
      r1_rate   <= s_rdata.rate;
      r1_diff_r <= DIFF_W'(s_rdata.phase) - DIFF_W'(w_r);
      r1_diff_l <= DIFF_W'(w_c) - DIFF_W'(w_r);
      r1_idx    <= d_pin[FRAC -: TAB_AW];
      r1_scale  <= p_rdata.scale;
      r1_prod_n <= $signed({1'b0, noise_gain}) * p_rdata.noise;
      r1_prod_s <= s_rdata.rate * $signed({1'b0, step_length});
    end
    if (v1) begin
      r2_site   <= r1_site;
      r2_phase  <= r1_phase;
      r2_scale  <= r1_scale;
      r2_prod_r <= $signed({1'b0, elastic_gain}) * r1_diff_r;
      r2_prod_l <= $signed({1'b0, elastic_gain}) * r1_diff_l;
      r2_sine   <= SINE_ROM[r1_idx];
      r2_sn     <= sat32(SAT_W'(r1_prod_n >>> FRAC));
    end
    if (v2) begin
      r3_site   <= r2_site;
      r3_phase  <= r2_phase;
      r3_el     <= EL_W'(r2_prod_r >>> FRAC) + EL_W'(r2_prod_l >>> FRAC);
      r3_prod_p <= $signed({1'b0, r2_scale}) * r2_sine;
      r3_force  <= sat32(SAT_W'(r2_sn) - SAT_W'(mean));
    end
  end

  assign rate_new  = sat32(SAT_W'(r3_el) - SAT_W'(r3_prod_p >>> FRAC)
                         + SAT_W'(r3_force) + SAT_W'(drive_field));
  assign phase_new = r1_phase + WORD_W'(r1_prod_s >>> FRAC);

  // RAM port steering
  always_comb begin
    s_we    = 1'b0;
    s_waddr = '0;
    s_wdata = '0;
    s_raddr = '0;
    p_we    = 1'b0;
    p_waddr = '0;
    p_wdata = '0;
    p_raddr = '0;
    case (state)
      ST_CLEAR: begin
        s_we    = 1'b1;
        p_we    = 1'b1;
        s_waddr = clr_cnt[SITE_AW-1:0];
        p_waddr = clr_cnt[SITE_AW-1:0];
      end
      ST_IDLE: begin
        s_raddr = item.site_index;
        p_raddr = item.site_index;
      end
      ST_ITEM: begin
        s_waddr = cur.site_index;
        p_waddr = cur.site_index;
        if (item_res.status == STATUS_OK) begin
          if (cur.kind == KIND_LOAD) begin
            s_we          = 1'b1;
            s_wdata.phase = cur.phase_value;
            s_wdata.rate  = '0;
            p_we          = 1'b1;
            p_wdata.scale = cur.pin_force_scale;
            p_wdata.angle = cur.pin_angle;
            p_wdata.noise = p_rdata.noise;
          end else if (cur.kind == KIND_NOISE) begin
            p_we          = 1'b1;
            p_wdata.scale = p_rdata.scale;
            p_wdata.angle = p_rdata.angle;
            p_wdata.noise = cur.noise_sample;
          end
        end
      end
      ST_SUM: begin
        p_raddr = rd_cnt[SITE_AW-1:0];
      end
      ST_RATE: begin
        if (rd_cnt == '0)                         s_raddr = SITE_AW'(n_len - LEN_W'(1));
        else if (rd_cnt == n_len + LEN_W'(1))     s_raddr = '0;
        else                                      s_raddr = SITE_AW'(rd_cnt - LEN_W'(1));
        p_raddr       = issue_site[SITE_AW-1:0];
        s_we          = v3;
        s_waddr       = r3_site;
        s_wdata.phase = r3_phase;
        s_wdata.rate  = rate_new;
      end
      ST_PHASE: begin
        s_raddr       = rd_cnt[SITE_AW-1:0];
        s_we          = v1;
        s_waddr       = r1_site;
        s_wdata.phase = phase_new;
        s_wdata.rate  = r1_rate;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/ppce_checker.sv
`timescale 1ns / 1ps
module ppce_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input ppce_pkg::out_word_t result,
  input logic                psel,
  input logic                penable,
  input logic                pready
);
  import ppce_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted word did not raise busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result shown while still busy");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status != STATUS_OK |-> result.phase_out == 0 && result.rate_out == 0)
    else $error("error result carries data");

  a_apb_ready: assert property (@(posedge clk) disable iff (rst)
    psel && penable |-> pready) else $error("config access stalled");

endmodule

bind pinned_phase_chain_euler_step_unit ppce_checker u_ppce_checker (.*);

>>> test/pinned_phase_chain_euler_step_unit_test.sv
`timescale 1ns / 1ps
module pinned_phase_chain_euler_step_unit_test;
  import ppce_pkg::*;

  // Scoreboard: keeps its own copy of the chain, works out the result word of
  // each accepted item and compares results against the oldest expectation.
  class chain_scoreboard;
    logic signed [WORD_W-1:0] phase_mem [CHAIN_DEPTH];
    logic signed [WORD_W-1:0] rate_mem  [CHAIN_DEPTH];
    logic [SCALE_W-1:0]       scale_mem [CHAIN_DEPTH];
    logic [ANGLE_W-1:0]       angle_mem [CHAIN_DEPTH];
    logic signed [WORD_W-1:0] noise_mem [CHAIN_DEPTH];
    logic signed [SINE_W-1:0] sine_tab  [TABLE_DEPTH];

    logic [LEN_W-1:0]         chain_len;
    logic [GAIN_W-1:0]        elastic;
    logic signed [WORD_W-1:0] field;
    logic [STEP_W-1:0]        dt;
    logic [GAIN_W-1:0]        jitter_gain;

    out_word_t pending[$];
    int        mismatches;

    function new();
      for (int k = 0; k < CHAIN_DEPTH; k++) begin
        phase_mem[k] = '0; rate_mem[k] = '0; scale_mem[k] = '0;
        angle_mem[k] = '0; noise_mem[k] = '0;
      end
      for (int k = 0; k < TABLE_DEPTH; k++) sine_tab[k] = sine_at(k);
      chain_len = LEN_W'(1024);
      elastic   = GAIN_W'(1 << FRAC);
      field     = '0;
      dt        = STEP_W'(167772);
      jitter_gain = '0;
      mismatches = 0;
    endfunction

    // quadrant fold, odd Taylor series in Q30, round half up to FRAC bits
    function automatic logic signed [SINE_W-1:0] sine_at(int unsigned k);
      logic [63:0] turn;
      logic [63:0] frac;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] acc;
      logic [63:0] mag;
      logic [1:0]  quad;
      turn = (64'(k) << 32) / TABLE_DEPTH;
      quad = turn[31:30];
      frac = (turn << 2) & 64'hFFFF_FFFF;
      if (quad[0]) frac = 64'h1_0000_0000 - frac;
      x   = (frac * 64'd1686629713) >> 32;
      x2  = (x * x) >> 30;
      acc = 64'd1073741824 - x2 / 110;
      acc = 64'd1073741824 - ((x2 * acc) >> 30) / 72;
      acc = 64'd1073741824 - ((x2 * acc) >> 30) / 42;
      acc = 64'd1073741824 - ((x2 * acc) >> 30) / 20;
      acc = 64'd1073741824 - ((x2 * acc) >> 30) / 6;
      mag = (x * acc) >> 30;
      mag = (mag + ((64'd1 << (30 - FRAC)) >> 1)) >> (30 - FRAC);
      return quad[1] ? -SINE_W'(mag) : SINE_W'(mag);
    endfunction

    function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function automatic int sites();
      if (chain_len < CHAIN_MIN_LEN) return CHAIN_MIN_LEN;
      if (chain_len > CHAIN_DEPTH) return CHAIN_DEPTH;
      return int'(chain_len);
    endfunction

    function automatic longint noise_at(int i);
      longint a;
      longint s;
      a = longint'(jitter_gain);
      s = noise_mem[i];
      return clip32((a * s) >>> FRAC);
    endfunction

    function void set_reg(int idx, logic [31:0] val);
      case (idx)
        0: chain_len = val[LEN_W-1:0];
        1: elastic   = val[GAIN_W-1:0];
        2: field     = val;
        3: dt        = val[STEP_W-1:0];
        4: jitter_gain = val[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    function void euler_step();
      int     n;
      longint sum;
      longint mean;
      longint period;
      longint p, rp, lp, d, m, ix, pin, el, pull, rate, dp;
      n = sites();
      sum = 0;
      period = 64'sd2 << FRAC;
      for (int i = 0; i < n; i++) sum += noise_at(i);
      mean = sum / n;
      for (int i = 0; i < n; i++) begin
        p  = phase_mem[i];
        rp = phase_mem[(i + 1) % n];
        lp = phase_mem[(i + n - 1) % n];
        d  = p - longint'(angle_mem[i]);
        m  = ((d % period) + period) % period;
        ix = (m * TABLE_DEPTH) / period;
        if (ix >= TABLE_DEPTH) ix = TABLE_DEPTH - 1;
        pin = -((longint'(scale_mem[i]) * longint'(sine_tab[ix])) >>> FRAC);
        el  = ((longint'(elastic) * (rp - p)) >>> FRAC)
            + ((longint'(elastic) * (lp - p)) >>> FRAC);
        pull = clip32(noise_at(i) - mean);
        rate = clip32(el + pin + pull + longint'(field));
        rate_mem[i] = rate[31:0];
      end
      for (int i = 0; i < n; i++) begin
        dp = (longint'(rate_mem[i]) * longint'(dt)) >>> FRAC;
        phase_mem[i] = phase_mem[i] + dp[31:0];
      end
    endfunction

    function void note_item(in_word_t w);
      out_word_t r;
      r = '0;
      r.status = STATUS_OK;
      if (w.kind == KIND_STEP) begin
        euler_step();
      end else if (int'(w.site_index) >= sites()) begin
        r.status = STATUS_RANGE;
      end else if (w.kind == KIND_LOAD) begin
        if (w.pin_angle > ANGLE_MAX) begin
          r.status = STATUS_ANGLE;
        end else begin
          phase_mem[w.site_index] = w.phase_value;
          scale_mem[w.site_index] = w.pin_force_scale;
          angle_mem[w.site_index] = w.pin_angle;
          rate_mem[w.site_index]  = '0;
        end
      end else if (w.kind == KIND_NOISE) begin
        noise_mem[w.site_index] = w.noise_sample;
      end else begin
        r.phase_out = phase_mem[w.site_index];
        r.rate_out  = rate_mem[w.site_index];
      end
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: status %0d/%0d phase %h/%h rate %h/%h (want/got)",
                   want.status, got.status, want.phase_out, got.phase_out,
                   want.rate_out, got.rate_out);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  in_word_t             item;
  logic                 done;
  out_word_t            result;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  chain_scoreboard sb = new();
  int burst_left = 0;

  pinned_phase_chain_euler_step_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #30_000_000;
    $display("Verification failed");
    $finish;
  end

  // sample handshakes at the rising edge; inputs only move on falling edges
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_item(item);
      if (done) sb.check_result(result);
    end
  end

  function automatic in_word_t make_word(logic [KIND_W-1:0] k, logic [SITE_AW-1:0] idx,
                                         logic [31:0] ph, logic [SCALE_W-1:0] sc,
                                         logic [ANGLE_W-1:0] ang, logic [31:0] nz);
    in_word_t w;
    w.kind = k; w.site_index = idx; w.phase_value = ph;
    w.pin_force_scale = sc; w.pin_angle = ang; w.noise_sample = nz;
    return w;
  endfunction

  // hold the word until the block takes it, then maybe pause between bursts
  task automatic send(in_word_t w);
    int gap;
    @(negedge clk);
    start <= 1'b1;
    item  <= w;
    do @(posedge clk); while (busy);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 30)
                                               : $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic apb_write(logic [PADDR_W-1:0] a, logic [31:0] d);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // registers change only with nothing in flight
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    wait (sb.pending.size() == 0);
    do @(posedge clk); while (busy);
  endtask

  task automatic configure(logic [31:0] n, logic [31:0] eg, logic [31:0] df,
                           logic [31:0] sl, logic [31:0] ng);
    logic [31:0] vals [5];
    vals = '{n, eg, df, sl, ng};
    wait_idle();
    for (int r = 0; r < NUM_REGS; r++) begin
      apb_write(PADDR_W'(4 * r), vals[r]);
      sb.set_reg(r, vals[r]);
    end
    // an address past the register map must be ignored
    apb_write(PADDR_W'(4 * $urandom_range(NUM_REGS, 7)), $urandom);
  endtask

  function automatic logic [ANGLE_W-1:0] some_angle();
    if ($urandom_range(0, 7) == 0) return ANGLE_W'($urandom);
    return ANGLE_W'($urandom_range(0, 2 << FRAC));
  endfunction

  initial begin
    int n_eff;
    int span;
    int count;
    logic [31:0] n_reg, eg, df, sl, ng;
    rst = 1'b1; start = 1'b0; item = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes at the reset settings (full 1024-site chain)
    send(make_word(KIND_LOAD, 0, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 0));
    send(make_word(KIND_LOAD, 1, 32'h8000_0000, 0, ANGLE_MAX, 32'hFFFF_FFFF));
    send(make_word(KIND_LOAD, 2, $urandom, 31'h1234_5678, ANGLE_W'(ANGLE_MAX + 1), 0));
    send(make_word(KIND_LOAD, 3, $urandom, 31'h7FFF_FFFF, 26'h3FF_FFFF, 0));
    send(make_word(KIND_LOAD, 1023, 32'h0100_0000, 31'h0100_0000, 26'h100_0000, 0));
    send(make_word(KIND_NOISE, 0, 0, 0, 0, 32'h7FFF_FFFF));
    send(make_word(KIND_NOISE, 1, 0, 0, 0, 32'h8000_0000));
    send(make_word(KIND_NOISE, 1023, 0, 0, 0, 32'h0100_0000));
    send(make_word(KIND_READ, 0, 0, 0, 0, 0));
    send(make_word(KIND_READ, 500, 0, 0, 0, 0));
    send(make_word(KIND_STEP, 1023, 0, 0, 0, 0));
    send(make_word(KIND_READ, 0, 0, 0, 0, 0));
    send(make_word(KIND_READ, 1, 0, 0, 0, 0));
    send(make_word(KIND_READ, 1023, 0, 0, 0, 0));

    // shortest chain with full noise: indices beyond the chain, stale noise
    configure(3, 31'h0100_0000, 0, 24'h02_0000, 31'h7FFF_FFFF);
    send(make_word(KIND_LOAD, 5, $urandom, $urandom, 0, 0));
    send(make_word(KIND_NOISE, 3, 0, 0, 0, $urandom));
    send(make_word(KIND_READ, 1023, 0, 0, 0, 0));
    send(make_word(KIND_LOAD, 2, 32'h0080_0000, 31'h0200_0000, 26'h180_0000, 0));
    send(make_word(KIND_NOISE, 2, 0, 0, 0, 32'hFF00_0000));
    send(make_word(KIND_STEP, 7, 0, 0, 0, 0));
    send(make_word(KIND_STEP, 0, 0, 0, 0, 0));
    send(make_word(KIND_READ, 0, 0, 0, 0, 0));
    send(make_word(KIND_READ, 1, 0, 0, 0, 0));
    send(make_word(KIND_READ, 2, 0, 0, 0, 0));

    // random phases, each under its own register settings
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin n_reg = 3;    eg = 31'h7FFF_FFFF; df = 32'h8000_0000;
                 sl = 24'hFF_FFFF; ng = 31'h7FFF_FFFF; end
        1: begin n_reg = 0;    eg = 0; df = 32'h7FFF_FFFF; sl = 0; ng = 0; end
        2: begin n_reg = 5;    eg = 31'h0100_0000; df = 0;
                 sl = $urandom & 24'hFF_FFFF; ng = 31'h0100_0000; end
        3: begin n_reg = 2047; eg = $urandom & 31'h7FFF_FFFF; df = $urandom;
                 sl = $urandom & 24'hFF_FFFF; ng = $urandom & 31'h7FFF_FFFF; end
        default: begin
          n_reg = $urandom_range(3, 16); eg = $urandom & 31'h7FFF_FFFF;
          df = $urandom; sl = $urandom & 24'hFF_FFFF; ng = $urandom & 31'h7FFF_FFFF;
        end
      endcase
      configure(n_reg, eg, df, sl, ng);
      n_eff = (n_reg[LEN_W-1:0] < CHAIN_MIN_LEN) ? CHAIN_MIN_LEN
            : (n_reg[LEN_W-1:0] > CHAIN_DEPTH) ? CHAIN_DEPTH : int'(n_reg[LEN_W-1:0]);
      span = (n_eff > 8) ? 8 : n_eff;
      count = 0;
      while (count < 30) begin
        if ($urandom_range(0, 3) == 0) begin
          // noise: any kind, any index, any angle
          send(make_word(KIND_W'($urandom), SITE_AW'($urandom), $urandom,
                         SCALE_W'($urandom), ANGLE_W'($urandom), $urandom));
          count++;
        end else begin
          // well-formed round: load, seed noise, step, read back
          for (int i = 0; i < span; i++)
            send(make_word(KIND_LOAD, SITE_AW'(i), $urandom, SCALE_W'($urandom),
                           some_angle(), 0));
          for (int i = 0; i < span; i++)
            if ($urandom_range(0, 3) != 0)
              send(make_word(KIND_NOISE, SITE_AW'(i), 0, 0, 0, $urandom));
          repeat ($urandom_range(1, 2))
            send(make_word(KIND_STEP, SITE_AW'($urandom), 0, 0, 0, 0));
          for (int i = 0; i < span; i++)
            send(make_word(KIND_READ, SITE_AW'(i), 0, 0, 0, 0));
          count += 3 * span + 1;
        end
      end
    end

    @(negedge clk);
    start <= 1'b0;
    wait (sb.pending.size() == 0);
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
